/* rtl/core/gn2o_pkg.sv */
// ----------------------------------------------------------------------------
// gn2o_pkg
// Shared types and constants of the fractal gradient noise block.
// ----------------------------------------------------------------------------
package gn2o_pkg;

	localparam int TABLE_SIZE_DEF      = 256;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int MAX_OCTAVES_DEF     = 16;

	localparam int COORD_W = 32;
	localparam int GRID_W  = 16;
	localparam int OCT_W   = 5;
	localparam int GRAD_W  = 16;
	localparam int PERM_W  = 8;
	localparam int OUT_W   = 19;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;

	localparam logic [1:0] REQ_LOAD_PERM = 2'd0;
	localparam logic [1:0] REQ_LOAD_GRAD = 2'd1;
	localparam logic [1:0] REQ_EVAL      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE    = 4'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OCT,
		ST_FIN
	} state_t;

	// Divider result: done pulses for one cycle, quot holds until the next start.
	typedef struct packed {
		logic                      done;
		logic signed [COORD_W:0]   quot;
	} div_res_t;

endpackage

/* rtl/core/gradient_noise_2d_octaves.sv */
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves
// Fractal 2D gradient noise over a permutation and a gradient memory.
// ----------------------------------------------------------------------------
// Load beats write one entry of the permutation or gradient memory in the
// cycle they are accepted. An evaluate beat first divides both coordinates by
// the grid size in a bit-serial divider, then runs a sequence per octave: six
// permutation reads and four gradient reads through the registered memory
// ports, followed by dot products, fade and blend on one shared multiplier.
// The input stays not ready until the result is registered. The result sits
// in an output register, so loads are accepted while it waits to be taken.
// Tables must be loaded before points are evaluated; unwritten entries read
// as unknown values.
module gradient_noise_2d_octaves #(
	parameter int COORD_FRAC_BITS = gn2o_pkg::COORD_FRAC_BITS_DEF,
	parameter int MAX_OCTAVES     = gn2o_pkg::MAX_OCTAVES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             req_type,
	input  logic [gn2o_pkg::PERM_W-1:0]            table_index,
	input  logic [gn2o_pkg::PERM_W-1:0]            perm_value,
	input  logic signed [gn2o_pkg::GRAD_W-1:0]     grad_x,
	input  logic signed [gn2o_pkg::GRAD_W-1:0]     grad_y,
	input  logic signed [gn2o_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [gn2o_pkg::COORD_W-1:0]    coord_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [gn2o_pkg::OUT_W-1:0]      noise_value,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [gn2o_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gn2o_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import gn2o_pkg::*;

	// Index wrapping relies on a power-of-two table.
	localparam int TABLE_SIZE = TABLE_SIZE_DEF;
	localparam int IW  = $clog2(TABLE_SIZE);
	localparam int F   = COORD_FRAC_BITS;
	localparam int PXW = F + IW;
	localparam int OPW = (F + 6 > 24) ? F + 6 : 24;
	localparam int MW  = 2 * OPW;
	localparam int AW  = OPW + 6;
	localparam int OCW = $clog2(MAX_OCTAVES + 1);
	localparam logic signed [OPW-1:0] ONE = OPW'(1) <<< F;

	// Sequence steps within one octave.
	localparam logic [4:0] SQ_DOT   = 5'd8;
	localparam logic [4:0] SQ_FADEY = 5'd16;
	localparam logic [4:0] SQ_FADEX = 5'd20;
	localparam logic [4:0] SQ_BLEND = 5'd24;
	localparam logic [4:0] SQ_LAST  = 5'd28;

	state_t state_q, state_d;

	logic [OCT_W-1:0]  oct_cnt_q;
	logic [GRID_W-1:0] grid_q;
	logic [GRID_W-1:0] grid_eff;

	logic [PERM_W-1:0]  perm_mem [TABLE_SIZE];
	logic [2*GRAD_W-1:0] grad_mem [TABLE_SIZE];
	logic [PERM_W-1:0]  perm_rd_q;
	logic [2*GRAD_W-1:0] grad_rd_q;
	logic [IW-1:0]      perm_addr;
	logic [IW-1:0]      grad_addr;

	logic in_acc, eval_start, perm_we, grad_we;
	div_res_t div_x, div_y;

	logic [PXW-1:0]       px_q, py_q;
	logic [OCW-1:0]       n_q, oct_q;
	logic [4:0]           step_q;
	logic [IW-1:0]        a0_q, a1_q;
	logic [2*GRAD_W-1:0]  g_q [4];
	logic signed [MW-1:0] prod_q, dacc_q;
	logic signed [OPW-1:0] v_q [4];
	logic signed [OPW-1:0] t2_q, c_q, sy_q, sx_q, vd_q, vu_q;
	logic signed [AW-1:0] acc_q;

	logic [IW-1:0]         cx, cy;
	logic signed [OPW-1:0] tx, ty, tf, psh, mul_a, mul_b, nz;
	logic [1:0]            cix;
	logic                  out_free, last_oct;

	assign grid_eff = (grid_q == '0) ? GRID_W'(1) : grid_q;
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && in_ready;
	assign eval_start = in_acc && (req_type == REQ_EVAL);
	assign perm_we = in_acc && (req_type == REQ_LOAD_PERM);
	assign grad_we = in_acc && (req_type == REQ_LOAD_GRAD);
	assign out_free = !out_valid || out_ready;
	assign last_oct = (oct_q + OCW'(1)) == n_q;

	gn2o_div u_div_x (
		.clk, .arst_n, .start(eval_start), .dividend(coord_x), .divisor(grid_eff),
		.res(div_x)
	);
	gn2o_div u_div_y (
		.clk, .arst_n, .start(eval_start), .dividend(coord_y), .divisor(grid_eff),
		.res(div_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cnt_q <= OCT_W'(1);
			grid_q    <= GRID_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OCTAVE_COUNT: oct_cnt_q <= cfg_data[OCT_W-1:0];
				CFG_GRID_SIZE:    grid_q    <= cfg_data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	// Memories: one write and one registered read port each.
	always_ff @(posedge clk) begin
		if (perm_we) perm_mem[IW'(table_index)] <= perm_value;
		perm_rd_q <= perm_mem[perm_addr];
	end

	always_ff @(posedge clk) begin
		if (grad_we) grad_mem[IW'(table_index)] <= {grad_y, grad_x};
		grad_rd_q <= grad_mem[grad_addr];
	end

	assign cx = px_q[PXW-1:F];
	assign cy = py_q[PXW-1:F];
	assign tx = OPW'(signed'({1'b0, px_q[F-1:0]}));
	assign ty = OPW'(signed'({1'b0, py_q[F-1:0]}));
	assign tf = (step_q < SQ_FADEX) ? ty : tx;
	assign psh = OPW'(prod_q >>> F);
	assign cix = step_q[2:1];
	assign nz = vd_q + psh;

	always_comb begin
		case (step_q)
			5'd1:    perm_addr = cx + IW'(1);
			5'd2:    perm_addr = a0_q + cy;
			5'd3:    perm_addr = a0_q + cy + IW'(1);
			5'd4:    perm_addr = a1_q + cy;
			5'd5:    perm_addr = a1_q + cy + IW'(1);
			default: perm_addr = cx;
		endcase
		grad_addr = IW'(perm_rd_q);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (step_q >= SQ_DOT && step_q < SQ_FADEY) begin
			if (!step_q[0]) begin
				mul_a = OPW'(signed'(g_q[cix][GRAD_W-1:0]));
				mul_b = cix[1] ? tx - ONE : tx;
			end else begin
				mul_a = OPW'(signed'(g_q[cix][2*GRAD_W-1:GRAD_W]));
				mul_b = cix[0] ? ty - ONE : ty;
			end
		end else begin
			case (step_q)
				SQ_FADEY, SQ_FADEX: begin
					mul_a = tf;
					mul_b = tf;
				end
				SQ_FADEY + 5'd1, SQ_FADEX + 5'd1: begin
					mul_a = tf;
					mul_b = OPW'(6) * tf - OPW'(15) * ONE;
				end
				SQ_FADEY + 5'd2, SQ_FADEX + 5'd2: begin
					mul_a = t2_q;
					mul_b = tf;
				end
				SQ_FADEY + 5'd3, SQ_FADEX + 5'd3: begin
					mul_a = psh;
					mul_b = c_q;
				end
				SQ_BLEND: begin
					mul_a = sy_q;
					mul_b = v_q[1] - v_q[0];
				end
				SQ_BLEND + 5'd1: begin
					mul_a = sy_q;
					mul_b = v_q[3] - v_q[2];
				end
				SQ_BLEND + 5'd3: begin
					mul_a = sx_q;
					mul_b = vu_q - vd_q;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (eval_start) state_d = ST_DIV;
			ST_DIV:  if (div_x.done) state_d = ST_OCT;
			ST_OCT:  if (step_q == SQ_LAST && last_oct) state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			step_q    <= '0;
		end else begin
			if (state_q == ST_FIN && out_free) out_valid <= 1'b1;
			else if (out_ready)                out_valid <= 1'b0;
			if (state_q == ST_OCT) step_q <= (step_q == SQ_LAST) ? '0 : step_q + 5'd1;
			else                   step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_start) begin
			if (oct_cnt_q == '0)                       n_q <= OCW'(1);
			else if (int'(oct_cnt_q) > MAX_OCTAVES)    n_q <= OCW'(MAX_OCTAVES);
			else                                       n_q <= OCW'(oct_cnt_q);
		end
		if (state_q == ST_DIV && div_x.done) begin
			px_q  <= PXW'(div_x.quot);
			py_q  <= PXW'(div_y.quot);
			oct_q <= '0;
			acc_q <= '0;
		end
		if (state_q == ST_FIN && out_free) begin
			if (acc_q < AW'(OUT_MIN))      noise_value <= OUT_MIN;
			else if (acc_q > AW'(OUT_MAX)) noise_value <= OUT_MAX;
			else                           noise_value <= acc_q[OUT_W-1:0];
		end
		if (state_q == ST_OCT) begin
			prod_q <= mul_a * mul_b;
			case (step_q)
				5'd1: a0_q <= IW'(perm_rd_q);
				5'd2: a1_q <= IW'(perm_rd_q);
				5'd4, 5'd5, 5'd6, 5'd7: g_q[step_q[1:0]] <= grad_rd_q;
				5'd9, 5'd11, 5'd13, 5'd15: dacc_q <= prod_q;
				5'd10, 5'd12, 5'd14, SQ_FADEY:
					v_q[cix - 2'd1] <= OPW'((dacc_q + prod_q) >>> (F - 2));
				SQ_FADEY + 5'd1, SQ_FADEX + 5'd1: t2_q <= psh;
				SQ_FADEY + 5'd2, SQ_FADEX + 5'd2: c_q <= psh + OPW'(10) * ONE;
				SQ_FADEX: sy_q <= psh;
				SQ_BLEND: sx_q <= psh;
				SQ_BLEND + 5'd1: vd_q <= v_q[0] + psh;
				SQ_BLEND + 5'd2: vu_q <= v_q[2] + psh;
				SQ_LAST: begin
					acc_q <= acc_q + (AW'(nz) >>> oct_q);
					oct_q <= oct_q + OCW'(1);
					px_q  <= px_q << 1;
					py_q  <= py_q << 1;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/gn2o_div.sv */
// ----------------------------------------------------------------------------
// gn2o_div
// Bit-serial floor division of a signed coordinate by the unsigned grid size.
// ----------------------------------------------------------------------------
module gn2o_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [gn2o_pkg::COORD_W-1:0] dividend,
	input  logic [gn2o_pkg::GRID_W-1:0]         divisor,
	output gn2o_pkg::div_res_t                  res
);
	import gn2o_pkg::*;

	localparam int CW = $clog2(COORD_W);

	logic [CW-1:0]      cnt_q;
	logic               run_q;
	logic               done_q;
	logic               neg_q;
	logic [COORD_W-1:0] quo_q;
	logic [GRID_W-1:0]  rem_q;
	logic [GRID_W-1:0]  dvs_q;
	logic [GRID_W:0]    trial;
	logic               ge;
	logic [COORD_W:0]   mag;

	assign trial = {rem_q, quo_q[COORD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == CW'(COORD_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(COORD_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// The divisor is held for the whole division.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[COORD_W-1];
			quo_q <= dividend[COORD_W-1] ? COORD_W'(-dividend) : COORD_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? GRID_W'(trial - {1'b0, dvs_q}) : trial[GRID_W-1:0];
			quo_q <= {quo_q[COORD_W-2:0], ge};
		end
	end

	// A negative dividend with a remainder rounds one further down.
	assign mag = {1'b0, quo_q} + ((rem_q != '0) ? (COORD_W+1)'(1) : '0);

	always_comb begin
		res.done = done_q;
		res.quot = neg_q ? -$signed(mag) : $signed({1'b0, quo_q});
	end

endmodule
